>>> rtl/core/hcd_pkg.sv
// shared types and constants of the hamiltonian cycle generator
`default_nettype none

package hcd_pkg;

	localparam int VTX_W  = 6;  // vertex number width
	localparam int NCNT_W = 7;  // vertex count register width
	localparam int SUCC_W = 7;  // successor entry width, room for the empty mark

	localparam logic [SUCC_W-1:0] NO_SUCC = 7'd127;

	localparam int          APB_ADDR_W         = 3;
	localparam logic        REG_VERTEX_COUNT   = 1'b0;  // register index bit paddr[2]
	localparam logic [NCNT_W-1:0] VERTEX_COUNT_RESET = 7'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_PREP,
		ST_ROW,
		ST_TAIL,
		ST_CLR,
		ST_BUILD_D,
		ST_BUILD_W,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_WALK_RD,
		ST_WALK_EM
	} state_t;

	typedef struct packed {
		logic             bad;
		logic             last;
		logic [VTX_W-1:0] vertex;
	} result_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [VTX_W-1:0]  addr;
		logic [SUCC_W-1:0] wdata;
	} succ_req_t;

	typedef struct packed {
		logic             we;
		logic             re;
		logic [VTX_W-1:0] addr;
		logic             wdata;
	} pred_req_t;

endpackage

`default_nettype wire

>>> rtl/core/hamilton_cycle_decomposition_gen_unit.sv
// top level of the hamiltonian cycle decomposition generator
`default_nettype none

// Emits one Hamiltonian cycle of a decomposition of the complete digraph on
// n = vertex_count vertices per request item; cycle_index picks the cycle
// (0 to n-2). Supported n: odd 3..MAX_VERTICES or a multiple of four
// 8..MAX_VERTICES; anything else, or an index past n-2, yields one error item
// (vertex 0, tlast and tuser high). Each valid request gives n vertex items, the
// last one (always n-1) marked with tlast. An odd-n cycle and a row cycle
// (index under n-2) of a multiple-of-four n come out at one vertex per cycle
// while the output is not stalled. The final cycle of a multiple-of-four n is
// rebuilt from the successor and predecessor rams (single port, registered
// read): a clearing pass over all MAX_VERTICES entries, one write per row
// to record the n-2 cut edges, a scan of the predecessor flags for the chain
// start, and a walk that reads each vertex's successor before emitting it.
// A new request is taken while the final result still waits at the output.
// vertex_count is written over the apb port (register 0); the user must do so
// only while idle, as the block itself does not enforce this.

module hamilton_cycle_decomposition_gen_unit #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// apb configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [hcd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// request items
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [5:0] cycle_index
	// result items
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // [5:0] vertex
	output logic                           m_tlast,   // last_in_cycle
	output logic                           m_tuser    // [0] bad_request
);

	localparam int AW = $clog2(MAX_VERTICES);

	logic [hcd_pkg::NCNT_W-1:0] vertex_count_q;
	logic                       cfg_wr;

	hcd_pkg::result_t   res;
	hcd_pkg::succ_req_t succ_req;
	hcd_pkg::pred_req_t pred_req;
	logic [hcd_pkg::SUCC_W-1:0] succ_rdata;
	logic                       pred_rdata;

	// apb: zero wait states, one register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[2] == hcd_pkg::REG_VERTEX_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= hcd_pkg::VERTEX_COUNT_RESET;
		end else if (cfg_wr) begin
			vertex_count_q <= pwdata[hcd_pkg::NCNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == hcd_pkg::REG_VERTEX_COUNT) ?
		{{(32 - hcd_pkg::NCNT_W){1'b0}}, vertex_count_q} : 32'd0;

	// sequencer with its output register
	hcd_ctrl #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_count (vertex_count_q),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.cycle_index  (s_tdata[hcd_pkg::VTX_W-1:0]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_item     (res),
		.succ_req     (succ_req),
		.succ_rdata   (succ_rdata),
		.pred_req     (pred_req),
		.pred_rdata   (pred_rdata)
	);

	// successor of each vertex on the chain of cut edges
	hcd_ram #(
		.WIDTH (hcd_pkg::SUCC_W),
		.DEPTH (MAX_VERTICES)
	) u_succ_ram (
		.clk   (clk),
		.we    (succ_req.we),
		.re    (succ_req.re),
		.addr  (succ_req.addr[AW-1:0]),
		.wdata (succ_req.wdata),
		.rdata (succ_rdata)
	);

	// predecessor flag of each vertex, used to find the chain start
	hcd_ram #(
		.WIDTH (1),
		.DEPTH (MAX_VERTICES)
	) u_pred_ram (
		.clk   (clk),
		.we    (pred_req.we),
		.re    (pred_req.re),
		.addr  (pred_req.addr[AW-1:0]),
		.wdata (pred_req.wdata),
		.rdata (pred_rdata)
	);

	// pack the result item onto the stream
	assign m_tdata = {{(8 - hcd_pkg::VTX_W){1'b0}}, res.vertex};
	assign m_tlast = res.last;
	assign m_tuser = res.bad;

endmodule

`default_nettype wire

>>> rtl/core/hcd_ram.sv
// generic single-port ram with registered read
`default_nettype none

module hcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/hcd_ctrl.sv
// sequencer: latin square rows, successor table build, chain walk, output register
`default_nettype none

module hcd_ctrl #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [hcd_pkg::NCNT_W-1:0]  vertex_count,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [hcd_pkg::VTX_W-1:0]   cycle_index,
	output logic                        out_valid,
	input  logic                        out_ready,
	output hcd_pkg::result_t            out_item,
	output hcd_pkg::succ_req_t          succ_req,
	input  logic [hcd_pkg::SUCC_W-1:0]  succ_rdata,
	output hcd_pkg::pred_req_t          pred_req,
	input  logic                        pred_rdata
);

	localparam int VW = hcd_pkg::VTX_W;
	localparam logic [VW-1:0] CLR_END = VW'(MAX_VERTICES - 1);
	localparam logic [hcd_pkg::NCNT_W-1:0] N_MAX = hcd_pkg::NCNT_W'(MAX_VERTICES);
	localparam logic [hcd_pkg::SUCC_W-1:0] SUCC_LIM = hcd_pkg::SUCC_W'(MAX_VERTICES);

	// element of row `row` at column `col` of the row-complete square of size s
	function automatic logic [VW-1:0] sq_elem(
		input logic [VW-1:0] s,
		input logic [VW-1:0] row,
		input logic [VW-1:0] col
	);
		logic [VW:0] base;
		logic [VW:0] sum;
		if (!col[0] && (col != '0)) begin
			base = {1'b0, s} - {2'b00, col[VW-1:1]};
		end else begin
			base = ({1'b0, col} + 7'd1) >> 1;
		end
		sum = base + {1'b0, row};
		if (sum >= {1'b0, s}) begin
			sum = sum - {1'b0, s};
		end
		return sum[VW-1:0];
	endfunction

	// row extended by s in its last position
	function automatic logic [VW-1:0] ext_elem(
		input logic [VW-1:0] s,
		input logic [VW-1:0] row,
		input logic [VW-1:0] p
	);
		return (p >= s) ? s : sq_elem(s, row, p);
	endfunction

	function automatic logic [VW-1:0] rot_point(
		input logic [VW-1:0] s,
		input logic [VW-1:0] k,
		input logic [VW-1:0] row
	);
		logic [VW-1:0] k2;
		logic [VW-1:0] k4;
		logic [VW-1:0] v;
		logic [VW-1:0] rp;
		k2 = {k[VW-2:0], 1'b0};
		k4 = {k[VW-3:0], 2'b00};
		v  = ext_elem(s, row, k2 - 6'd1);
		priority if (v == k) begin
			rp = '0;
		end else if (v == k2 + 6'd1) begin
			rp = k4 + 6'd1;
		end else if (v == k + k2 + 6'd2) begin
			rp = 6'd2;
		end else if (v == '0) begin
			rp = k4 - 6'd1;
		end else begin
			rp = k2 - 6'd1;
		end
		return rp;
	endfunction

	hcd_pkg::state_t  state_q, state_d;
	logic [VW-1:0]    idx_q, idx_d;
	logic [VW-1:0]    pos_q, pos_d;
	logic [VW-1:0]    cnt_q, cnt_d;
	logic [VW-1:0]    d_q, d_d;
	logic             out_valid_q;
	hcd_pkg::result_t out_q;

	logic                       emit;
	hcd_pkg::result_t           item;
	logic                       can_emit;
	logic [hcd_pkg::NCNT_W-1:0] n;
	logic [hcd_pkg::NCNT_W-1:0] s_wide;
	logic [hcd_pkg::NCNT_W-1:0] nm1_wide;
	logic [VW-1:0]              s;
	logic [VW-1:0]              k;
	logic [VW-1:0]              row_end;
	logic                       odd_ok, quad_ok, idx_big;
	logic                       in_build;
	logic [VW-1:0]              row0, col0;
	logic [VW-1:0]              elem0, elem1, rot_d;

	assign n        = vertex_count;
	assign s_wide   = n[0] ? (n - 7'd1) : (n - 7'd2);
	assign s        = s_wide[VW-1:0];
	assign nm1_wide = n - 7'd1;
	assign k        = {1'b0, n[hcd_pkg::NCNT_W-1:2]} - 6'd1;
	assign row_end  = n[0] ? (s - 6'd1) : s;
	assign odd_ok   = n[0] && (n >= 7'd3) && (n <= N_MAX);
	assign quad_ok  = (n[1:0] == 2'b00) && (n >= 7'd8) && (n <= N_MAX);
	assign idx_big  = {1'b0, cycle_index} > (n - 7'd2);

	assign in_build = (state_q == hcd_pkg::ST_BUILD_W);
	assign row0     = in_build ? cnt_q : idx_q;
	assign col0     = in_build ? d_q : pos_q;
	assign elem0    = ext_elem(s, row0, col0);
	assign elem1    = (d_q == '0) ? s : ext_elem(s, cnt_q, d_q - 6'd1);
	assign rot_d    = rot_point(s, k, (state_q == hcd_pkg::ST_PREP) ? idx_q : cnt_q);

	assign can_emit = !out_valid_q || out_ready;
	assign in_ready = (state_q == hcd_pkg::ST_IDLE);

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		pos_d    = pos_q;
		cnt_d    = cnt_q;
		d_d      = d_q;
		emit     = 1'b0;
		item     = '0;
		succ_req = '0;
		pred_req = '0;
		unique case (state_q)
			hcd_pkg::ST_IDLE: begin
				if (in_valid) begin
					idx_d = cycle_index;
					pos_d = '0;
					cnt_d = '0;
					priority if (!(odd_ok || quad_ok) || idx_big) begin
						state_d = hcd_pkg::ST_ERR;
					end else if (odd_ok) begin
						state_d = hcd_pkg::ST_ROW;
					end else if (cycle_index == s) begin
						state_d = hcd_pkg::ST_CLR;
					end else begin
						state_d = hcd_pkg::ST_PREP;
					end
				end
			end
			hcd_pkg::ST_ERR: begin
				if (can_emit) begin
					emit      = 1'b1;
					item.last = 1'b1;
					item.bad  = 1'b1;
					state_d   = hcd_pkg::ST_IDLE;
				end
			end
			hcd_pkg::ST_PREP: begin
				pos_d   = rot_d;
				cnt_d   = '0;
				state_d = hcd_pkg::ST_ROW;
			end
			hcd_pkg::ST_ROW: begin
				if (can_emit) begin
					emit        = 1'b1;
					item.vertex = elem0;
					pos_d       = (pos_q == s) ? '0 : pos_q + 6'd1;
					cnt_d       = cnt_q + 6'd1;
					if (cnt_q == row_end) begin
						state_d = hcd_pkg::ST_TAIL;
					end
				end
			end
			hcd_pkg::ST_TAIL: begin
				if (can_emit) begin
					emit        = 1'b1;
					item.vertex = nm1_wide[VW-1:0];
					item.last   = 1'b1;
					state_d     = hcd_pkg::ST_IDLE;
				end
			end
			hcd_pkg::ST_CLR: begin
				succ_req.we    = 1'b1;
				succ_req.addr  = cnt_q;
				succ_req.wdata = hcd_pkg::NO_SUCC;
				pred_req.we    = 1'b1;
				pred_req.addr  = cnt_q;
				pred_req.wdata = 1'b0;
				if (cnt_q == CLR_END) begin
					cnt_d   = '0;
					state_d = hcd_pkg::ST_BUILD_D;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			hcd_pkg::ST_BUILD_D: begin
				d_d     = rot_d;
				state_d = hcd_pkg::ST_BUILD_W;
			end
			hcd_pkg::ST_BUILD_W: begin
				// the edge cut by this row's rotation
				succ_req.we    = 1'b1;
				succ_req.addr  = elem1;
				succ_req.wdata = {1'b0, elem0};
				pred_req.we    = 1'b1;
				pred_req.addr  = elem0;
				pred_req.wdata = 1'b1;
				if (cnt_q == s - 6'd1) begin
					cnt_d   = '0;
					state_d = hcd_pkg::ST_SCAN_RD;
				end else begin
					cnt_d   = cnt_q + 6'd1;
					state_d = hcd_pkg::ST_BUILD_D;
				end
			end
			hcd_pkg::ST_SCAN_RD: begin
				pred_req.re   = 1'b1;
				pred_req.addr = cnt_q;
				state_d       = hcd_pkg::ST_SCAN_CHK;
			end
			hcd_pkg::ST_SCAN_CHK: begin
				priority if (!pred_rdata) begin
					pos_d   = cnt_q;
					cnt_d   = '0;
					state_d = hcd_pkg::ST_WALK_RD;
				end else if (cnt_q == s) begin
					pos_d   = '0;
					cnt_d   = '0;
					state_d = hcd_pkg::ST_WALK_RD;
				end else begin
					cnt_d   = cnt_q + 6'd1;
					state_d = hcd_pkg::ST_SCAN_RD;
				end
			end
			hcd_pkg::ST_WALK_RD: begin
				succ_req.re   = 1'b1;
				succ_req.addr = pos_q;
				state_d       = hcd_pkg::ST_WALK_EM;
			end
			hcd_pkg::ST_WALK_EM: begin
				if (can_emit) begin
					emit        = 1'b1;
					item.vertex = pos_q;
					cnt_d       = cnt_q + 6'd1;
					if ((cnt_q == s) || (succ_rdata >= SUCC_LIM)) begin
						state_d = hcd_pkg::ST_TAIL;
					end else begin
						pos_d   = succ_rdata[VW-1:0];
						state_d = hcd_pkg::ST_WALK_RD;
					end
				end
			end
			default: begin
				state_d = hcd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hcd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		pos_q <= pos_d;
		cnt_q <= cnt_d;
		d_q   <= d_d;
		if (emit) begin
			out_q <= item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && item.last) |=> (state_q == hcd_pkg::ST_IDLE))
		else $error("sequencer did not return to idle after the last result");

	a_bad_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.bad) |-> (out_q.last && (out_q.vertex == '0)))
		else $error("error result without last mark or with nonzero vertex");

	a_build_real_succ: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hcd_pkg::ST_BUILD_W) |-> (succ_req.we && (succ_req.wdata != hcd_pkg::NO_SUCC)))
		else $error("build step wrote the empty successor mark");

	a_scan_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hcd_pkg::ST_SCAN_CHK) |-> ($past(state_q) == hcd_pkg::ST_SCAN_RD))
		else $error("predecessor check without a read in the previous cycle");

	a_walk_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hcd_pkg::ST_WALK_RD) |=> (state_q == hcd_pkg::ST_WALK_EM))
		else $error("successor read not followed by its check");
`endif

endmodule

`default_nettype wire

>>> tb/hcd_cycle_checker.sv
// hamiltonian cycle checker: predicts and compares every vertex item and apb read
module hcd_cycle_checker #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [hcd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	input  logic [31:0]                    prdata,
	input  logic                           pready,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [7:0]                     s_tdata,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [7:0]                     m_tdata,
	input  logic                           m_tlast,
	input  logic                           m_tuser,
	output int                             outstanding,
	output int                             error_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [hcd_pkg::NCNT_W-1:0] vertex_count;
	logic [hcd_pkg::SUCC_W-1:0] chain_next [MAX_VERTICES];
	logic                       chain_entered [MAX_VERTICES];
	hcd_pkg::result_t           pending_vertices [$];

	// element col of row `row` of the row-complete latin square of size s
	function automatic int unsigned latin_elem(input int unsigned s, input int unsigned row,
			input int unsigned col);
		int unsigned base;
		base = (col % 2 == 0 && col > 0) ? s - col / 2 : (col + 1) / 2;
		return (base + row) % s;
	endfunction

	// same row extended by s at position s
	function automatic int unsigned ext_row_elem(input int unsigned s, input int unsigned row,
			input int unsigned p);
		return (p >= s) ? s : latin_elem(s, row, p);
	endfunction

	// rotation point of an extended row, picked by its element 2k-1
	function automatic int unsigned cut_point(input int unsigned s, input int unsigned k,
			input int unsigned row);
		int unsigned v;
		v = ext_row_elem(s, row, 2 * k - 1);
		if (v == k) return 0;
		if (v == 2 * k + 1) return 4 * k + 1;
		if (v == 3 * k + 2) return 2;
		if (v == 0) return 4 * k - 1;
		return 2 * k - 1;
	endfunction

	task automatic push_vertex(input int unsigned v, input logic last, input logic bad);
		hcd_pkg::result_t r;
		r.vertex = v[hcd_pkg::VTX_W-1:0];
		r.last   = last;
		r.bad    = bad;
		pending_vertices.insert(pending_vertices.size(), r);
	endtask

	task automatic predict_cycle(input logic [hcd_pkg::VTX_W-1:0] idx_bits);
		int unsigned n, idx, s, k, len, d, a, b, start, cnt, v, nx, i, j;
		bit odd_ok, quad_ok;
		n = vertex_count;
		idx = idx_bits;
		odd_ok  = (n % 2 == 1) && n >= 3 && n <= MAX_VERTICES;
		quad_ok = (n % 4 == 0) && n >= 8 && n <= MAX_VERTICES;
		if ((!odd_ok && !quad_ok) || idx > n - 2) begin
			push_vertex(0, 1'b1, 1'b1);
		end else if (odd_ok) begin
			s = n - 1;
			for (j = 0; j < s; j++)
				push_vertex(latin_elem(s, idx, j), 1'b0, 1'b0);
			push_vertex(n - 1, 1'b1, 1'b0);
		end else begin
			s = n - 2;
			k = n / 4 - 1;
			len = s + 1;
			if (idx < s) begin
				d = cut_point(s, k, idx);
				for (j = 0; j < len; j++)
					push_vertex(ext_row_elem(s, idx, (d + j) % len), 1'b0, 1'b0);
			end else begin
				// final cycle: chain of the edges cut by every rotation
				for (i = 0; i < MAX_VERTICES; i++) begin
					chain_next[i] = hcd_pkg::NO_SUCC;
					chain_entered[i] = 1'b0;
				end
				for (i = 0; i < s; i++) begin
					d = cut_point(s, k, i);
					a = ext_row_elem(s, i, (d + len - 1) % len);
					b = ext_row_elem(s, i, d);
					chain_next[a] = b[hcd_pkg::SUCC_W-1:0];
					chain_entered[b] = 1'b1;
				end
				start = 0;
				for (i = n - 1; i > 0; i--)
					if (!chain_entered[i - 1])
						start = i - 1;
				v = start;
				cnt = 0;
				while (cnt < n - 1) begin
					push_vertex(v, 1'b0, 1'b0);
					cnt++;
					nx = chain_next[v];
					if (nx == hcd_pkg::NO_SUCC || nx >= MAX_VERTICES)
						break;
					v = nx;
				end
			end
			push_vertex(n - 1, 1'b1, 1'b0);
		end
	endtask

	task automatic note_failure(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		hcd_pkg::result_t got, want;
		if (!arst_n) begin
			vertex_count = hcd_pkg::VERTEX_COUNT_RESET;
			for (int i = 0; i < MAX_VERTICES; i++) begin
				chain_next[i] = hcd_pkg::NO_SUCC;
				chain_entered[i] = 1'b0;
			end
			pending_vertices.delete();
			error_count = 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pready && paddr[2] == hcd_pkg::REG_VERTEX_COUNT) begin
				if (pwrite)
					vertex_count = pwdata[hcd_pkg::NCNT_W-1:0];
				else if (prdata !== {25'd0, vertex_count})
					note_failure($sformatf("vertex_count read expected %0d actual %0d",
						vertex_count, prdata));
			end
			if (m_tvalid && m_tready) begin
				got.vertex = m_tdata[hcd_pkg::VTX_W-1:0];
				got.last   = m_tlast;
				got.bad    = m_tuser;
				if (pending_vertices.size() == 0) begin
					note_failure($sformatf("unexpected item vertex %0d last %0b bad %0b",
						got.vertex, got.last, got.bad));
				end else begin
					want = pending_vertices.pop_front();
					if (got.vertex !== want.vertex || got.last !== want.last ||
							got.bad !== want.bad)
						note_failure($sformatf(
							"expected vertex %0d last %0b bad %0b, actual vertex %0d last %0b bad %0b",
							want.vertex, want.last, want.bad, got.vertex, got.last, got.bad));
				end
			end
			if (s_tvalid && s_tready)
				predict_cycle(s_tdata[hcd_pkg::VTX_W-1:0]);
			outstanding <= pending_vertices.size();
		end
	end

endmodule

>>> tb/tb_hamilton_cycle_decomposition_gen_unit.sv
// top of the hamiltonian cycle generator testbench: clock, reset, stimulus and verdict
module tb_hamilton_cycle_decomposition_gen_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_VERTICES = 64;
	localparam int SETTLE_CYCLES = 8;     // quiet cycles after the last expected item
	localparam int CHOKE_CYCLES = 400;    // one long receiver hold-off
	localparam int RANDOM_ITEMS = 80;
	localparam logic [hcd_pkg::APB_ADDR_W-1:0] VERTEX_COUNT_ADDR =
		{hcd_pkg::REG_VERTEX_COUNT, 2'b00};

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [hcd_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [31:0]                    pwdata = '0;
	logic [31:0]                    prdata;
	logic                           pready;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata = '0;    // [5:0] cycle_index
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [7:0]                     m_tdata;         // [5:0] vertex
	logic                           m_tlast;
	logic                           m_tuser;
	int                             outstanding;
	int                             error_count;
	logic                           choke_req = 1'b0;  // asks the receiver for its long hold-off
	int unsigned                    burst_left = 0;

	hamilton_cycle_decomposition_gen_unit #(.MAX_VERTICES(MAX_VERTICES)) dut (.*);

	hcd_cycle_checker #(.MAX_VERTICES(MAX_VERTICES)) u_cycle_checker (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// reset held at the start, released once
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// run limit, far above the slowest correct run
	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: random stall patterns, plus one long hold-off on request
	initial begin : rx_ready_pattern
		int unsigned mode, run;
		bit choked;
		choked = 0;
		run = 0;
		mode = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (choke_req && !choked) begin
				choked = 1;
				m_tready <= 1'b0;
				repeat (CHOKE_CYCLES) @(posedge clk);
			end else begin
				if (run == 0) begin
					mode = $urandom_range(0, 3);
					run = $urandom_range(5, 60);
				end
				case (mode)
					0: m_tready <= 1'b1;                          // no stalls at all
					1: m_tready <= ($urandom_range(0, 1) == 1);
					2: m_tready <= ($urandom_range(0, 7) == 0);   // mostly stalled
					default: m_tready <= ($urandom_range(0, 3) != 0);
				endcase
				run--;
				@(posedge clk);
			end
		end
	end

	// one apb transfer: setup, access, then the port released
	task automatic apb_access(input logic write, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= VERTEX_COUNT_ADDR;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// write n and read it back, the checker compares the read
	task automatic set_vertex_count(input int unsigned n);
		apb_access(1'b1, 32'(n));
		apb_access(1'b0, 32'd0);
	endtask

	// offer one request item and wait for its handshake, tvalid stays high
	task automatic send_request(input int unsigned idx);
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, idx[5:0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic idle_sender(input int unsigned cycles);
		if (cycles != 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= {2'b00, 6'($urandom_range(0, 63))};
			repeat (cycles) @(posedge clk);
		end
	endtask

	// bursts of random length separated by random gaps
	task automatic pace_sender();
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
				: $urandom_range(1, 8);
			idle_sender($urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 20));
		end else begin
			burst_left--;
		end
	endtask

	// sender pauses until every expected item is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic bit supported_count(input int unsigned n);
		return (n % 2 == 1 && n >= 3 && n <= MAX_VERTICES)
			|| (n % 4 == 0 && n >= 8 && n <= MAX_VERTICES);
	endfunction

	// mostly small supported sizes, a few of the largest and some unsupported
	function automatic int unsigned pick_vertex_count();
		int unsigned r, n;
		r = $urandom_range(0, 9);
		if (r <= 3) begin
			n = 2 * $urandom_range(1, 10) + 1;
		end else if (r <= 6) begin
			n = 4 * $urandom_range(2, 5);
		end else if (r == 7) begin
			n = ($urandom_range(0, 1) == 1) ? 64 : 63;
		end else begin
			n = $urandom_range(0, 64);
			while (supported_count(n)) n = $urandom_range(0, 64);
		end
		return n;
	endfunction

	// well-formed indexes most of the time, the final cycle often, a few out of range
	function automatic int unsigned pick_index(input int unsigned n);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (!supported_count(n) || r == 9)
			return $urandom_range(0, 63);
		if (r >= 7)
			return n - 2;
		return $urandom_range(0, n - 2);
	endfunction

	initial begin : stimulus
		int unsigned n, items, sent, phase;
		wait (arst_n);
		@(posedge clk);

		// reset value n = 3: both cycles, the first bad index and the widest index
		send_request(0);
		send_request(1);
		send_request(2);
		send_request(63);
		drain_results();

		// smallest multiple of four: every row cycle, the chained final cycle, one past
		set_vertex_count(8);
		for (int i = 0; i <= 7; i++)
			send_request(i);
		drain_results();

		// largest size: first row, a middle row, final cycle, out of range
		set_vertex_count(64);
		send_request(0);
		send_request(31);
		send_request(62);
		send_request(63);
		drain_results();

		// unsupported counts: zero, one, and four (multiple of four below eight)
		set_vertex_count(0);
		send_request(0);
		drain_results();
		set_vertex_count(1);
		send_request(0);
		drain_results();
		set_vertex_count(4);
		send_request(2);
		drain_results();

		// largest odd count: last valid index and the first bad one
		set_vertex_count(63);
		send_request(61);
		send_request(62);
		drain_results();

		// random phases, a new vertex count each time
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			n = (phase == 2) ? 4 * $urandom_range(3, 6) : pick_vertex_count();
			set_vertex_count(n);
			items = $urandom_range(4, 14);
			// hold the receiver off while requests keep coming back to back
			if (phase == 2)
				choke_req <= 1'b1;
			for (int i = 0; i < items; i++) begin
				send_request(pick_index(n));
				sent++;
				if (phase == 4 && i == items / 2)
					drain_results();
				else if (phase != 2)
					pace_sender();
			end
			drain_results();
			phase++;
		end

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> hamilton_cycle_decomposition_gen_unit.f
rtl/core/hcd_pkg.sv
rtl/core/hcd_ram.sv
rtl/core/hcd_ctrl.sv
rtl/core/hamilton_cycle_decomposition_gen_unit.sv
tb/hcd_cycle_checker.sv
tb/tb_hamilton_cycle_decomposition_gen_unit.sv
